[design/dmf_pkg.sv]
// ============================================================================
// dmf_pkg: shared types and constants of the maximum flow engine
// Widths, operation and status codes, and the command and status bundles
// between the controller and the datapath.
// ============================================================================
package dmf_pkg;

    localparam int NODES     = 64;
    localparam int EDGES     = 1024;
    localparam int NODE_W    = 6;
    localparam int COUNT_W   = 7;
    localparam int EIDX_W    = 10;
    localparam int ELINK_W   = 11;
    localparam int CAP_W     = 40;
    localparam int RES_W     = 41;
    localparam int FLOW_W    = 48;
    localparam int LEVEL_W   = 7;
    localparam int DEPTH_W   = 7;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;

    localparam logic [ELINK_W-1:0] EDGE_NULL  = ELINK_W'(EDGES);
    localparam logic [LEVEL_W-1:0] LEVEL_NONE = LEVEL_W'(NODES);
    localparam logic [FLOW_W-1:0]  FLOW_MAX   = '1;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SELF_LOOP = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_NODE  = 2'd3;

    typedef struct packed {
        logic [EIDX_W-1:0]  head_rd_addr;
        logic [EIDX_W-1:0]  edge_rd_addr;
        logic               edge_we;
        logic               res_we;
        logic [EIDX_W-1:0]  edge_wr_addr;
        logic [NODE_W-1:0]  head_wr_data;
        logic [RES_W-1:0]   res_wr_data;
        logic [ELINK_W-1:0] next_wr_data;
        logic [NODE_W-1:0]  first_rd_addr;
        logic               first_we;
        logic               first_clr;
        logic [NODE_W-1:0]  first_wr_addr;
        logic [ELINK_W-1:0] first_wr_data;
        logic [NODE_W-1:0]  level_rd_addr;
        logic               level_we;
        logic               level_clr;
        logic [NODE_W-1:0]  level_wr_addr;
        logic [NODE_W-1:0]  level_wr_data;
        logic [NODE_W-1:0]  level_chk_addr;
        logic [NODE_W-1:0]  cur_rd_addr;
        logic               cur_we;
        logic               cur_clr;
        logic [NODE_W-1:0]  cur_wr_addr;
        logic [ELINK_W-1:0] cur_wr_data;
        logic [NODE_W-1:0]  queue_rd_addr;
        logic               queue_we;
        logic [NODE_W-1:0]  queue_wr_addr;
        logic [NODE_W-1:0]  queue_wr_data;
        logic [NODE_W-1:0]  stack_rd_addr;
        logic               stack_we;
        logic [NODE_W-1:0]  stack_wr_addr;
        logic [ELINK_W-1:0] stack_wr_data;
    } dmf_cmd_t;

    typedef struct packed {
        logic [NODE_W-1:0]  head_q;
        logic [RES_W-1:0]   res_q;
        logic [ELINK_W-1:0] next_q;
        logic [ELINK_W-1:0] first_q;
        logic [LEVEL_W-1:0] level_q;
        logic               level_chk;
        logic [ELINK_W-1:0] cur_q;
        logic               cur_valid_q;
        logic [NODE_W-1:0]  queue_q;
        logic [ELINK_W-1:0] stack_q;
    } dmf_stat_t;

endpackage

[design/dmf_item_if.sv]
// ============================================================================
// dmf_item_if: input channel of the maximum flow engine
// Valid/ready channel carrying one operation per beat.
// ============================================================================
interface dmf_item_if;
    logic                            valid;
    logic                            ready;
    logic [dmf_pkg::OP_W-1:0]        op;
    logic [dmf_pkg::COUNT_W-1:0]     node_count;
    logic [dmf_pkg::NODE_W-1:0]      from_node;
    logic [dmf_pkg::NODE_W-1:0]      to_node;
    logic [dmf_pkg::CAP_W-1:0]       capacity;
    logic                            bidirectional;
    logic [dmf_pkg::NODE_W-1:0]      source_node;
    logic [dmf_pkg::NODE_W-1:0]      sink_node;

    modport source (output valid, op, node_count, from_node, to_node, capacity,
                    bidirectional, source_node, sink_node, input ready);
    modport sink (input valid, op, node_count, from_node, to_node, capacity,
                  bidirectional, source_node, sink_node, output ready);
endinterface

// ============================================================================
// dmf_result_if: output channel of the maximum flow engine
// Valid/ready channel carrying one result per beat.
// ============================================================================
interface dmf_result_if;
    logic                            valid;
    logic                            ready;
    logic [dmf_pkg::FLOW_W-1:0]      flow_value;
    logic [dmf_pkg::STATUS_W-1:0]    status;

    modport source (output valid, flow_value, status, input ready);
    modport sink (input valid, flow_value, status, output ready);
endinterface

[design/dmf_datapath.sv]
// ============================================================================
// dmf_datapath: graph storage of the maximum flow engine
// Edge memories, per-node memories with valid bits, search queue and path
// stack. All reads are registered but the level valid check.
// ============================================================================
module dmf_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  dmf_pkg::dmf_cmd_t   cmd,
    output dmf_pkg::dmf_stat_t  stat
);

    logic [dmf_pkg::NODE_W-1:0]  head_mem  [dmf_pkg::EDGES];
    logic [dmf_pkg::RES_W-1:0]   res_mem   [dmf_pkg::EDGES];
    logic [dmf_pkg::ELINK_W-1:0] next_mem  [dmf_pkg::EDGES];
    logic [dmf_pkg::ELINK_W-1:0] first_mem [dmf_pkg::NODES];
    logic [dmf_pkg::NODE_W-1:0]  level_mem [dmf_pkg::NODES];
    logic [dmf_pkg::ELINK_W-1:0] cur_mem   [dmf_pkg::NODES];
    logic [dmf_pkg::NODE_W-1:0]  queue_mem [dmf_pkg::NODES];
    logic [dmf_pkg::ELINK_W-1:0] stack_mem [dmf_pkg::NODES];

    logic [dmf_pkg::NODES-1:0]   first_vld_reg;
    logic [dmf_pkg::NODES-1:0]   level_vld_reg;
    logic [dmf_pkg::NODES-1:0]   cur_vld_reg;

    logic [dmf_pkg::ELINK_W-1:0] first_data_reg;
    logic                        first_hit_reg;
    logic [dmf_pkg::NODE_W-1:0]  level_data_reg;
    logic                        level_hit_reg;

    logic [dmf_pkg::NODE_W-1:0]  head_q_reg;
    logic [dmf_pkg::RES_W-1:0]   res_q_reg;
    logic [dmf_pkg::ELINK_W-1:0] next_q_reg;
    logic [dmf_pkg::ELINK_W-1:0] cur_q_reg;
    logic                        cur_hit_reg;
    logic [dmf_pkg::NODE_W-1:0]  queue_q_reg;
    logic [dmf_pkg::ELINK_W-1:0] stack_q_reg;

    // Edge memories.
    always_ff @(posedge clk)
    begin
        if (cmd.edge_we)
        begin
            head_mem[cmd.edge_wr_addr] <= cmd.head_wr_data;
            next_mem[cmd.edge_wr_addr] <= cmd.next_wr_data;
        end
        if (cmd.edge_we || cmd.res_we)
        begin
            res_mem[cmd.edge_wr_addr] <= cmd.res_wr_data;
        end
        head_q_reg <= head_mem[cmd.head_rd_addr];
        res_q_reg  <= res_mem[cmd.edge_rd_addr];
        next_q_reg <= next_mem[cmd.edge_rd_addr];
    end

    // Per-node memories, queue and stack.
    always_ff @(posedge clk)
    begin
        if (cmd.first_we)
        begin
            first_mem[cmd.first_wr_addr] <= cmd.first_wr_data;
        end
        if (cmd.level_we)
        begin
            level_mem[cmd.level_wr_addr] <= cmd.level_wr_data;
        end
        if (cmd.cur_we)
        begin
            cur_mem[cmd.cur_wr_addr] <= cmd.cur_wr_data;
        end
        if (cmd.queue_we)
        begin
            queue_mem[cmd.queue_wr_addr] <= cmd.queue_wr_data;
        end
        if (cmd.stack_we)
        begin
            stack_mem[cmd.stack_wr_addr] <= cmd.stack_wr_data;
        end
        first_data_reg <= first_mem[cmd.first_rd_addr];
        level_data_reg <= level_mem[cmd.level_rd_addr];
        cur_q_reg      <= cur_mem[cmd.cur_rd_addr];
        queue_q_reg    <= queue_mem[cmd.queue_rd_addr];
        stack_q_reg    <= stack_mem[cmd.stack_rd_addr];
    end

    // Valid bits; an invalid first-edge or level entry reads as its empty value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_vld_reg <= '0;
            level_vld_reg <= '0;
            cur_vld_reg   <= '0;
            first_hit_reg <= 1'b0;
            level_hit_reg <= 1'b0;
            cur_hit_reg   <= 1'b0;
        end
        else
        begin
            first_hit_reg <= first_vld_reg[cmd.first_rd_addr];
            level_hit_reg <= level_vld_reg[cmd.level_rd_addr];
            cur_hit_reg   <= cur_vld_reg[cmd.cur_rd_addr];
            if (cmd.first_clr)
            begin
                first_vld_reg <= '0;
            end
            else if (cmd.first_we)
            begin
                first_vld_reg[cmd.first_wr_addr] <= 1'b1;
            end
            // A new level pass clears every level and marks the source at once.
            if (cmd.level_clr)
            begin
                level_vld_reg <= cmd.level_we ?
                                 ({{(dmf_pkg::NODES-1){1'b0}}, 1'b1} << cmd.level_wr_addr) :
                                 '0;
            end
            else if (cmd.level_we)
            begin
                level_vld_reg[cmd.level_wr_addr] <= 1'b1;
            end
            if (cmd.cur_clr)
            begin
                cur_vld_reg <= '0;
            end
            else if (cmd.cur_we)
            begin
                cur_vld_reg[cmd.cur_wr_addr] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        stat             = '0;
        stat.head_q      = head_q_reg;
        stat.res_q       = res_q_reg;
        stat.next_q      = next_q_reg;
        stat.first_q     = first_hit_reg ? first_data_reg : dmf_pkg::EDGE_NULL;
        stat.level_q     = level_hit_reg ? {1'b0, level_data_reg} : dmf_pkg::LEVEL_NONE;
        stat.level_chk   = level_vld_reg[cmd.level_chk_addr];
        stat.cur_q       = cur_q_reg;
        stat.cur_valid_q = cur_hit_reg;
        stat.queue_q     = queue_q_reg;
        stat.stack_q     = stack_q_reg;
    end

endmodule

[design/dmf_ctrl.sv]
// ============================================================================
// dmf_ctrl: sequencer of the maximum flow engine
// Handles the channels, the graph loading and the level and blocking-flow
// phases, driving the datapath through a command bundle.
// ============================================================================
module dmf_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    dmf_item_if.sink            item,
    dmf_result_if.source        result,
    output dmf_pkg::dmf_cmd_t   cmd,
    input  dmf_pkg::dmf_stat_t  stat
);

    typedef enum logic [4:0] {
        S_IDLE, S_ADD_FWD, S_ADD_BWD,
        S_LP_INIT, S_LP_POP, S_LP_U, S_LP_FIRST, S_LP_EDGE, S_LP_EHEAD, S_LP_END,
        S_BF_INIT, S_BF_NODE, S_BF_CUR, S_BF_SCAN, S_BF_SCAN2, S_BF_SCAN3,
        S_BF_SET, S_BF_POP, S_BF_POP2,
        S_AUG_MIN_RD, S_AUG_MIN_E, S_AUG_MIN_R,
        S_AUG_UPD_RD, S_AUG_UPD_E, S_AUG_UPD_F, S_AUG_UPD_B, S_AUG_TOTAL,
        S_DONE
    } state_t;

    localparam int NW = dmf_pkg::NODE_W;
    localparam int EW = dmf_pkg::EIDX_W;

    state_t                        state_reg, state_next;
    logic [dmf_pkg::COUNT_W-1:0]   nodes_reg, nodes_next;
    logic [dmf_pkg::ELINK_W-1:0]   edges_reg, edges_next;
    logic [NW-1:0]                 src_reg, src_next;
    logic [NW-1:0]                 snk_reg, snk_next;
    logic [NW-1:0]                 a_reg, a_next;
    logic [NW-1:0]                 b_reg, b_next;
    logic [dmf_pkg::CAP_W-1:0]     cap_reg, cap_next;
    logic                          bidir_reg, bidir_next;
    logic [NW-1:0]                 u_reg, u_next;
    logic [NW-1:0]                 v_reg, v_next;
    logic [dmf_pkg::ELINK_W-1:0]   e_reg, e_next;
    logic [dmf_pkg::ELINK_W-1:0]   nxt_reg, nxt_next;
    logic [dmf_pkg::RES_W-1:0]     res_reg, res_next;
    logic [dmf_pkg::LEVEL_W-1:0]   ulev_reg, ulev_next;
    logic [dmf_pkg::DEPTH_W-1:0]   depth_reg, depth_next;
    logic [dmf_pkg::DEPTH_W-1:0]   k_reg, k_next;
    logic [dmf_pkg::DEPTH_W-1:0]   qh_reg, qh_next;
    logic [dmf_pkg::DEPTH_W-1:0]   qt_reg, qt_next;
    logic [dmf_pkg::RES_W-1:0]     f_reg, f_next;
    logic [dmf_pkg::FLOW_W-1:0]    total_reg, total_next;
    logic [dmf_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic                          out_valid_reg, out_valid_next;
    logic [dmf_pkg::FLOW_W-1:0]    out_flow_reg, out_flow_next;
    logic [dmf_pkg::STATUS_W-1:0]  out_status_reg, out_status_next;

    logic                          accept;
    logic [dmf_pkg::FLOW_W:0]      sum;
    logic [dmf_pkg::LEVEL_W-1:0]   want_lev;
    logic [dmf_pkg::DEPTH_W-1:0]   depth_dec;

    assign item.ready        = (state_reg == S_IDLE);
    assign accept            = item.valid && item.ready;
    assign result.valid      = out_valid_reg;
    assign result.flow_value = out_flow_reg;
    assign result.status     = out_status_reg;

    assign sum       = {1'b0, total_reg} + (dmf_pkg::FLOW_W+1)'(f_reg);
    assign want_lev  = ulev_reg + dmf_pkg::LEVEL_W'(1);
    assign depth_dec = depth_reg - dmf_pkg::DEPTH_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        nodes_next      = nodes_reg;
        edges_next      = edges_reg;
        src_next        = src_reg;
        snk_next        = snk_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        cap_next        = cap_reg;
        bidir_next      = bidir_reg;
        u_next          = u_reg;
        v_next          = v_reg;
        e_next          = e_reg;
        nxt_next        = nxt_reg;
        res_next        = res_reg;
        ulev_next       = ulev_reg;
        depth_next      = depth_reg;
        k_next          = k_reg;
        qh_next         = qh_reg;
        qt_next         = qt_reg;
        f_next          = f_reg;
        total_next      = total_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_flow_next   = out_flow_reg;
        out_status_next = out_status_reg;
        cmd             = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    total_next  = '0;
                    status_next = dmf_pkg::ST_OK;
                    state_next  = S_DONE;
                    a_next      = item.from_node;
                    b_next      = item.to_node;
                    cap_next    = item.capacity;
                    bidir_next  = item.bidirectional;
                    src_next    = item.source_node;
                    snk_next    = item.sink_node;
                    cmd.first_rd_addr = item.from_node;
                    case (item.op)
                        dmf_pkg::OP_CLEAR:
                        begin
                            cmd.first_clr = 1'b1;
                            edges_next    = '0;
                            if (item.node_count == '0)
                            begin
                                nodes_next  = dmf_pkg::COUNT_W'(1);
                                status_next = dmf_pkg::ST_BAD_NODE;
                            end
                            else if (item.node_count > dmf_pkg::COUNT_W'(dmf_pkg::NODES))
                            begin
                                nodes_next  = dmf_pkg::COUNT_W'(dmf_pkg::NODES);
                                status_next = dmf_pkg::ST_BAD_NODE;
                            end
                            else
                            begin
                                nodes_next = item.node_count;
                            end
                        end
                        dmf_pkg::OP_ADD:
                        begin
                            if ({1'b0, item.from_node} >= nodes_reg ||
                                {1'b0, item.to_node} >= nodes_reg)
                            begin
                                status_next = dmf_pkg::ST_BAD_NODE;
                            end
                            else if (item.from_node == item.to_node)
                            begin
                                status_next = dmf_pkg::ST_SELF_LOOP;
                            end
                            else if ({1'b0, edges_reg} + 12'd2 > 12'(dmf_pkg::EDGES))
                            begin
                                status_next = dmf_pkg::ST_FULL;
                            end
                            else
                            begin
                                state_next = S_ADD_FWD;
                            end
                        end
                        dmf_pkg::OP_RUN:
                        begin
                            if ({1'b0, item.source_node} >= nodes_reg ||
                                {1'b0, item.sink_node} >= nodes_reg)
                            begin
                                status_next = dmf_pkg::ST_BAD_NODE;
                            end
                            else if (item.source_node != item.sink_node)
                            begin
                                state_next = S_LP_INIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_ADD_FWD:
            begin
                cmd.edge_we       = 1'b1;
                cmd.edge_wr_addr  = edges_reg[EW-1:0];
                cmd.head_wr_data  = b_reg;
                cmd.res_wr_data   = {1'b0, cap_reg};
                cmd.next_wr_data  = stat.first_q;
                cmd.first_we      = 1'b1;
                cmd.first_wr_addr = a_reg;
                cmd.first_wr_data = edges_reg;
                cmd.first_rd_addr = b_reg;
                state_next        = S_ADD_BWD;
            end

            S_ADD_BWD:
            begin
                cmd.edge_we       = 1'b1;
                cmd.edge_wr_addr  = edges_reg[EW-1:0] | EW'(1);
                cmd.head_wr_data  = a_reg;
                cmd.res_wr_data   = bidir_reg ? {1'b0, cap_reg} : '0;
                cmd.next_wr_data  = stat.first_q;
                cmd.first_we      = 1'b1;
                cmd.first_wr_addr = b_reg;
                cmd.first_wr_data = edges_reg | dmf_pkg::ELINK_W'(1);
                edges_next        = edges_reg + dmf_pkg::ELINK_W'(2);
                state_next        = S_DONE;
            end

            // Level pass: breadth-first search from the source.
            S_LP_INIT:
            begin
                cmd.level_clr     = 1'b1;
                cmd.level_we      = 1'b1;
                cmd.level_wr_addr = src_reg;
                cmd.level_wr_data = '0;
                cmd.queue_we      = 1'b1;
                cmd.queue_wr_addr = '0;
                cmd.queue_wr_data = src_reg;
                qh_next           = '0;
                qt_next           = dmf_pkg::DEPTH_W'(1);
                state_next        = S_LP_POP;
            end

            S_LP_POP:
            begin
                if (qh_reg == qt_reg)
                begin
                    state_next = S_LP_END;
                end
                else
                begin
                    cmd.queue_rd_addr = qh_reg[NW-1:0];
                    qh_next           = qh_reg + dmf_pkg::DEPTH_W'(1);
                    state_next        = S_LP_U;
                end
            end

            S_LP_U:
            begin
                u_next            = stat.queue_q;
                cmd.first_rd_addr = stat.queue_q;
                cmd.level_rd_addr = stat.queue_q;
                state_next        = (stat.queue_q == snk_reg) ? S_LP_END : S_LP_FIRST;
            end

            S_LP_FIRST:
            begin
                e_next     = stat.first_q;
                ulev_next  = stat.level_q;
                state_next = S_LP_EDGE;
            end

            S_LP_EDGE:
            begin
                cmd.head_rd_addr = e_reg[EW-1:0];
                cmd.edge_rd_addr = e_reg[EW-1:0];
                state_next       = (e_reg == dmf_pkg::EDGE_NULL) ? S_LP_POP : S_LP_EHEAD;
            end

            S_LP_EHEAD:
            begin
                cmd.level_chk_addr = stat.head_q;
                if (stat.res_q != '0 && !stat.level_chk &&
                    qt_reg < dmf_pkg::DEPTH_W'(dmf_pkg::NODES))
                begin
                    cmd.level_we      = 1'b1;
                    cmd.level_wr_addr = stat.head_q;
                    cmd.level_wr_data = want_lev[NW-1:0];
                    cmd.queue_we      = 1'b1;
                    cmd.queue_wr_addr = qt_reg[NW-1:0];
                    cmd.queue_wr_data = stat.head_q;
                    qt_next           = qt_reg + dmf_pkg::DEPTH_W'(1);
                end
                e_next     = stat.next_q;
                state_next = S_LP_EDGE;
            end

            S_LP_END:
            begin
                cmd.level_chk_addr = snk_reg;
                state_next         = stat.level_chk ? S_BF_INIT : S_DONE;
            end

            // Blocking flow: depth-first walk along level-increasing edges.
            S_BF_INIT:
            begin
                cmd.cur_clr = 1'b1;
                u_next      = src_reg;
                depth_next  = '0;
                state_next  = S_BF_NODE;
            end

            S_BF_NODE:
            begin
                cmd.cur_rd_addr   = u_reg;
                cmd.first_rd_addr = u_reg;
                cmd.level_rd_addr = u_reg;
                k_next            = '0;
                f_next            = '1;
                state_next        = (u_reg == snk_reg) ? S_AUG_MIN_RD : S_BF_CUR;
            end

            S_BF_CUR:
            begin
                e_next     = stat.cur_valid_q ? stat.cur_q : stat.first_q;
                ulev_next  = stat.level_q;
                state_next = S_BF_SCAN;
            end

            S_BF_SCAN:
            begin
                cmd.head_rd_addr = e_reg[EW-1:0];
                cmd.edge_rd_addr = e_reg[EW-1:0];
                state_next       = (e_reg == dmf_pkg::EDGE_NULL) ? S_BF_SET : S_BF_SCAN2;
            end

            S_BF_SCAN2:
            begin
                v_next            = stat.head_q;
                res_next          = stat.res_q;
                nxt_next          = stat.next_q;
                cmd.level_rd_addr = stat.head_q;
                state_next        = S_BF_SCAN3;
            end

            S_BF_SCAN3:
            begin
                if (res_reg != '0 && stat.level_q == want_lev)
                begin
                    state_next = S_BF_SET;
                end
                else
                begin
                    e_next     = nxt_reg;
                    state_next = S_BF_SCAN;
                end
            end

            S_BF_SET:
            begin
                cmd.cur_we      = 1'b1;
                cmd.cur_wr_addr = u_reg;
                cmd.cur_wr_data = e_reg;
                if (e_reg != dmf_pkg::EDGE_NULL &&
                    depth_reg < dmf_pkg::DEPTH_W'(dmf_pkg::NODES))
                begin
                    cmd.stack_we      = 1'b1;
                    cmd.stack_wr_addr = depth_reg[NW-1:0];
                    cmd.stack_wr_data = e_reg;
                    depth_next        = depth_reg + dmf_pkg::DEPTH_W'(1);
                    u_next            = v_reg;
                    state_next        = S_BF_NODE;
                end
                else if (depth_reg == '0)
                begin
                    state_next = S_LP_INIT;
                end
                else
                begin
                    depth_next        = depth_dec;
                    cmd.stack_rd_addr = depth_dec[NW-1:0];
                    state_next        = S_BF_POP;
                end
            end

            S_BF_POP:
            begin
                cmd.head_rd_addr = stat.stack_q[EW-1:0] ^ EW'(1);
                cmd.edge_rd_addr = stat.stack_q[EW-1:0];
                state_next       = S_BF_POP2;
            end

            S_BF_POP2:
            begin
                u_next          = stat.head_q;
                cmd.cur_we      = 1'b1;
                cmd.cur_wr_addr = stat.head_q;
                cmd.cur_wr_data = stat.next_q;
                state_next      = S_BF_NODE;
            end

            // Augmentation: bottleneck over the path, then residual update.
            S_AUG_MIN_RD:
            begin
                cmd.stack_rd_addr = k_reg[NW-1:0];
                if (k_reg == depth_reg)
                begin
                    k_next     = '0;
                    state_next = S_AUG_UPD_RD;
                end
                else
                begin
                    state_next = S_AUG_MIN_E;
                end
            end

            S_AUG_MIN_E:
            begin
                cmd.edge_rd_addr = stat.stack_q[EW-1:0];
                state_next       = S_AUG_MIN_R;
            end

            S_AUG_MIN_R:
            begin
                if (stat.res_q < f_reg)
                begin
                    f_next = stat.res_q;
                end
                k_next     = k_reg + dmf_pkg::DEPTH_W'(1);
                state_next = S_AUG_MIN_RD;
            end

            S_AUG_UPD_RD:
            begin
                cmd.stack_rd_addr = k_reg[NW-1:0];
                state_next        = (k_reg == depth_reg) ? S_AUG_TOTAL : S_AUG_UPD_E;
            end

            S_AUG_UPD_E:
            begin
                e_next           = stat.stack_q;
                cmd.edge_rd_addr = stat.stack_q[EW-1:0];
                state_next       = S_AUG_UPD_F;
            end

            S_AUG_UPD_F:
            begin
                cmd.res_we       = 1'b1;
                cmd.edge_wr_addr = e_reg[EW-1:0];
                cmd.res_wr_data  = stat.res_q - f_reg;
                cmd.edge_rd_addr = e_reg[EW-1:0] ^ EW'(1);
                state_next       = S_AUG_UPD_B;
            end

            S_AUG_UPD_B:
            begin
                cmd.res_we       = 1'b1;
                cmd.edge_wr_addr = e_reg[EW-1:0] ^ EW'(1);
                cmd.res_wr_data  = stat.res_q + f_reg;
                k_next           = k_reg + dmf_pkg::DEPTH_W'(1);
                state_next       = S_AUG_UPD_RD;
            end

            S_AUG_TOTAL:
            begin
                if (sum >= {1'b0, dmf_pkg::FLOW_MAX})
                begin
                    total_next = dmf_pkg::FLOW_MAX;
                end
                else
                begin
                    total_next = sum[dmf_pkg::FLOW_W-1:0];
                end
                depth_next = '0;
                u_next     = src_reg;
                state_next = S_BF_NODE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_flow_next   = total_reg;
                    out_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            nodes_reg     <= dmf_pkg::COUNT_W'(1);
            edges_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nodes_reg     <= nodes_next;
            edges_reg     <= edges_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg        <= src_next;
        snk_reg        <= snk_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        cap_reg        <= cap_next;
        bidir_reg      <= bidir_next;
        u_reg          <= u_next;
        v_reg          <= v_next;
        e_reg          <= e_next;
        nxt_reg        <= nxt_next;
        res_reg        <= res_next;
        ulev_reg       <= ulev_next;
        depth_reg      <= depth_next;
        k_reg          <= k_next;
        qh_reg         <= qh_next;
        qt_reg         <= qt_next;
        f_reg          <= f_next;
        total_reg      <= total_next;
        status_reg     <= status_next;
        out_flow_reg   <= out_flow_next;
        out_status_reg <= out_status_next;
    end

endmodule

[design/dinic_max_flow_engine.sv]
// ============================================================================
// dinic_max_flow_engine: maximum flow by Dinic's method
// Loads a graph one beat at a time and computes its maximum flow on request.
// ============================================================================
// The item channel takes one operation per beat: clear (sets the node count
// and empties the edge store), add (stores an edge and its partner back edge)
// or run (computes the maximum flow from source_node to sink_node). Every
// item returns exactly one beat on the result channel with flow_value and
// status; flow_value is nonzero only for a successful run.
// Clear and rejected items go straight to the result; an add writes the
// forward edge and then the back edge, since the tail and head adjacency
// lists are linked through one read port of the first-edge memory in turn.
// A run repeats a level pass, which dequeues nodes and scans their edges,
// and a depth-first walk, which steps forward or back and passes over edges,
// and an augmentation along each path that the walk finds. Items are taken
// one at a time: the item channel is ready only while the sequencer is idle.
// Reset empties the edge store and sets the node count to one; no clearing
// pass is needed since node lists are tracked by valid bits. A finished
// result sits in an output register; while the receiver stalls the next item
// is still accepted and processed, and its result waits for the slot to free.
// ============================================================================
module dinic_max_flow_engine
(
    input  logic           clk,
    input  logic           rst_n,
    dmf_item_if.sink       item,
    dmf_result_if.source   result
);

    dmf_pkg::dmf_cmd_t  cmd;
    dmf_pkg::dmf_stat_t stat;

    // Sequencer: channel handshakes, graph loading and the search phases.
    dmf_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cmd    (cmd),
        .stat   (stat)
    );

    // Storage: edge store with residuals, node lists, levels, queue, stack.
    dmf_datapath u_datapath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule
